// ===== hw/rtl/rvopd_pkg.sv =====
// Shared types, operation codes and the instruction pattern table of the RV32I operand decoder.
package rvopd_pkg;

	localparam int unsigned ENTRY_COUNT = 29;

	// Operation-unit codes as they appear on the result.
	typedef enum logic [4:0] {
		UNIT_ADD   = 5'd0,
		UNIT_SLTU  = 5'd1,
		UNIT_SLT   = 5'd2,
		UNIT_AND   = 5'd3,
		UNIT_OR    = 5'd4,
		UNIT_XOR   = 5'd5,
		UNIT_SLL   = 5'd6,
		UNIT_SRL   = 5'd7,
		UNIT_SRA   = 5'd8,
		UNIT_LUI   = 5'd9,
		UNIT_AUIPC = 5'd10,
		UNIT_SUB   = 5'd11,
		UNIT_LB    = 5'd12,
		UNIT_LH    = 5'd13,
		UNIT_LW    = 5'd14,
		UNIT_LBU   = 5'd15,
		UNIT_LHU   = 5'd16,
		UNIT_SB    = 5'd17,
		UNIT_SH    = 5'd18,
		UNIT_SW    = 5'd19
	} unit_t;

	// Operand formats.
	typedef enum logic [1:0] {
		FMT_I = 2'd0,
		FMT_U = 2'd1,
		FMT_R = 2'd2,
		FMT_S = 2'd3
	} fmt_t;

	typedef struct packed {
		logic [31:0] mask;
		logic [31:0] match;
		unit_t       unit;
		fmt_t        fmt;
	} pattern_t;

	// Outcome of the pattern match, handed from the match stage to the operand stage.
	typedef struct packed {
		logic  supported;
		unit_t unit;
		fmt_t  fmt;
	} match_t;

	// One decoded result item.
	typedef struct packed {
		logic               supported;
		unit_t              op_unit;
		logic [4:0]         dest_field;
		logic               first_is_reg;
		logic signed [20:0] first_value;
		logic               second_is_reg;
		logic signed [11:0] second_value;
		logic               is_load_store;
		logic signed [12:0] branch_disp;
	} result_t;

	// Mask/match patterns; the first entry that matches wins.
	localparam pattern_t PATTERNS [ENTRY_COUNT] = '{
		'{32'h0000707F, 32'h00000013, UNIT_ADD,   FMT_I},
		'{32'h0000707F, 32'h00003013, UNIT_SLTU,  FMT_I},
		'{32'h0000707F, 32'h00002013, UNIT_SLT,   FMT_I},
		'{32'h0000707F, 32'h00007013, UNIT_AND,   FMT_I},
		'{32'h0000707F, 32'h00006013, UNIT_OR,    FMT_I},
		'{32'h0000707F, 32'h00004013, UNIT_XOR,   FMT_I},
		'{32'hFE00707F, 32'h00001013, UNIT_SLL,   FMT_I},
		'{32'hFE00707F, 32'h00005013, UNIT_SRL,   FMT_I},
		'{32'hFE00707F, 32'h40005013, UNIT_SRA,   FMT_I},
		'{32'h0000007F, 32'h00000037, UNIT_LUI,   FMT_U},
		'{32'h0000007F, 32'h00000017, UNIT_AUIPC, FMT_U},
		'{32'hFE00707F, 32'h00000033, UNIT_ADD,   FMT_R},
		'{32'hFE00707F, 32'h00002033, UNIT_SLT,   FMT_R},
		'{32'hFE00707F, 32'h00003033, UNIT_SLTU,  FMT_R},
		'{32'hFE00707F, 32'h00001033, UNIT_SLL,   FMT_R},
		'{32'hFE00707F, 32'h40000033, UNIT_SUB,   FMT_R},
		'{32'hFE00707F, 32'h00007033, UNIT_AND,   FMT_R},
		'{32'hFE00707F, 32'h00006033, UNIT_OR,    FMT_R},
		'{32'hFE00707F, 32'h00004033, UNIT_XOR,   FMT_R},
		'{32'hFE00707F, 32'h00005033, UNIT_SRL,   FMT_R},
		'{32'hFE00707F, 32'h40005033, UNIT_SRA,   FMT_R},
		'{32'h0000707F, 32'h00000003, UNIT_LB,    FMT_I},
		'{32'h0000707F, 32'h00001003, UNIT_LH,    FMT_I},
		'{32'h0000707F, 32'h00002003, UNIT_LW,    FMT_I},
		'{32'h0000707F, 32'h00004003, UNIT_LBU,   FMT_I},
		'{32'h0000707F, 32'h00005003, UNIT_LHU,   FMT_I},
		'{32'h0000707F, 32'h00000023, UNIT_SB,    FMT_S},
		'{32'h0000707F, 32'h00001023, UNIT_SH,    FMT_S},
		'{32'h0000707F, 32'h00002023, UNIT_SW,    FMT_S}
	};

endpackage

// ===== hw/rtl/rvopd_match.sv =====
// Pattern match of one instruction word against the supported instruction table.
module rvopd_match
	import rvopd_pkg::*;
(
	input  logic [31:0] word,
	output match_t      hit
);

	// Walk from the last entry down so that the earliest matching entry is left standing.
	always_comb begin
		hit = '0;
		for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
			if ((word & PATTERNS[i].mask) == PATTERNS[i].match) begin
				hit.supported = 1'b1;
				hit.unit      = PATTERNS[i].unit;
				hit.fmt       = PATTERNS[i].fmt;
			end
		end
	end

endmodule

// ===== hw/rtl/rvopd_operand.sv =====
// Operand formation: destination, operands and branch offset from a matched word.
module rvopd_operand
	import rvopd_pkg::*;
(
	input  logic [31:0] word,
	input  match_t      hit,
	output result_t     res
);

	logic [4:0] rd;
	logic [4:0] rs1;
	logic [4:0] rs2;

	assign rd  = word[11:7];
	assign rs1 = word[19:15];
	assign rs2 = word[24:20];

	always_comb begin
		res = '0;
		// The branch offset is decoded from every word, supported or not.
		res.branch_disp = {word[31], word[7], word[30:25], word[11:8], 1'b0};
		if (hit.supported) begin
			res.supported     = 1'b1;
			res.op_unit       = hit.unit;
			res.is_load_store = (hit.unit >= UNIT_LB);
			unique case (hit.fmt)
				FMT_I: begin
					res.dest_field    = rd;
					res.first_is_reg  = 1'b1;
					res.first_value   = {16'd0, rs1};
					res.second_is_reg = 1'b0;
					res.second_value  = word[31:20];
				end
				FMT_U: begin
					res.dest_field    = rd;
					res.first_is_reg  = 1'b0;
					res.first_value   = {1'b0, word[31:12]};
					res.second_is_reg = 1'b1;
					res.second_value  = '1;
				end
				FMT_R: begin
					res.dest_field    = rd;
					res.first_is_reg  = 1'b1;
					res.first_value   = {16'd0, rs1};
					res.second_is_reg = 1'b1;
					res.second_value  = {7'd0, rs2};
				end
				FMT_S: begin
					res.dest_field    = rs1;
					res.first_is_reg  = 1'b0;
					res.first_value   = {{9{word[31]}}, word[31:25], word[11:7]};
					res.second_is_reg = 1'b1;
					res.second_value  = {7'd0, rs2};
				end
				default: begin
					res.dest_field = rd;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/rv32i_subset_operand_decoder.sv =====
// Top level of the RV32I subset operand decoder: three-stage pipeline with stream handshakes.
// The decoder takes one 32-bit RISC-V instruction word per item and checks it against the
// RV32I patterns of 29 instructions (ALU immediate, LUI and AUIPC, ALU register, loads and
// stores). Each result item carries a supported flag, an operation-unit code, the destination
// field, two operands each marked as a register index or an immediate, a load/store flag and
// the B-type branch offset of the same word. Unsupported words give zeros in every field but
// the branch offset. As in the original decoder, the U immediate is given unshifted with -1 as
// its second operand, and stores put rs1 in the destination field. The pipeline has three
// register stages: the input word is registered, the pattern match is registered, and the
// formed operands sit in the output register. An item accepted at the input passes through
// the match register into the output register before it can be taken, and one item is
// accepted in every cycle as long as the output side takes them; a stall at the output backs
// up through the stages without losing or repeating anything, and only a full pipeline holds
// off the input.
module rv32i_subset_operand_decoder
	import rvopd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] instr_word
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // [4:0] op_unit, [9:5] dest_field, [30:10] first_value,
	                                   // [42:31] second_value, [55:43] branch_disp
	output logic [3:0]  m_axis_tuser   // [0] supported, [1] first_is_reg, [2] second_is_reg,
	                                   // [3] is_load_store
);

	// Stage valid bits.
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	// Stage payloads.
	logic [31:0] word_s1;
	logic [31:0] word_s2;
	match_t      hit_s2;
	result_t     res_s3;

	// Combinational results between the stages.
	match_t  hit;
	result_t res;

	// A stage may load when it is empty or when its contents move on in the same cycle.
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;

	assign ready_s3 = !valid_s3 || m_axis_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign s_axis_tready = ready_s1;

	rvopd_match u_match (
		.word (word_s1),
		.hit  (hit)
	);

	rvopd_operand u_operand (
		.word (word_s2),
		.hit  (hit_s2),
		.res  (res)
	);

	// Valid bits travel with the data and are the only state that reset clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Payload registers load only when an item actually moves into the stage.
	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			word_s1 <= s_axis_tdata;
		end
		if (ready_s2 && valid_s1) begin
			word_s2 <= word_s1;
			hit_s2  <= hit;
		end
		if (ready_s3 && valid_s2) begin
			res_s3 <= res;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {res_s3.branch_disp, res_s3.second_value, res_s3.first_value,
	                        res_s3.dest_field, res_s3.op_unit};
	assign m_axis_tuser  = {res_s3.is_load_store, res_s3.second_is_reg, res_s3.first_is_reg,
	                        res_s3.supported};

`ifndef SYNTHESIS
	// An unsupported word leaves every field but the branch offset at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !res_s3.supported |->
			res_s3.op_unit == UNIT_ADD && res_s3.dest_field == 5'd0 &&
			res_s3.first_value == 21'sd0 && res_s3.second_value == 12'sd0 &&
			m_axis_tuser == 4'd0)
		else $error("unsupported word produced non-zero fields");

	// The load/store flag follows the operation-unit code.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> res_s3.is_load_store == (res_s3.op_unit >= UNIT_LB))
		else $error("load/store flag disagrees with op_unit");

	// Every supported format with an immediate first operand has a register second operand.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && res_s3.supported && !res_s3.first_is_reg |-> res_s3.second_is_reg)
		else $error("immediate first operand without register second operand");

	// The input is held off only when every stage is full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && valid_s3 && !m_axis_tready)
		else $error("input stalled while the pipeline had room");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the RV32I subset operand decoder: stream stimulus and scoreboard.
module testbench;
	import rvopd_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_TICKS = 9;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_TICKS = 8;

	// Major opcodes of the instruction groups the decoder knows.
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;

	// funct3 values of the ALU groups.
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// funct3 values of loads and stores (access width).
	localparam logic [2:0] F3_BYTE   = 3'd0;
	localparam logic [2:0] F3_HALF   = 3'd1;
	localparam logic [2:0] F3_WORD   = 3'd2;
	localparam logic [2:0] F3_BYTE_U = 3'd4;
	localparam logic [2:0] F3_HALF_U = 3'd5;

	// funct7 values: the base encoding and the alternate one used by SUB and SRA/SRAI.
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// An instruction word waiting for its decoded result, kept for the mismatch message.
	typedef struct {
		logic [31:0] word;
		result_t     res;
	} pending_decode_t;

	// Scoreboard: predicts the decode of every accepted word and checks results in order.
	class decode_scoreboard;
		pending_decode_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// Decodes a word by its opcode, funct3 and funct7 fields.
		function result_t decode_word(logic [31:0] w);
			result_t r;
			logic hit;
			unit_t u;
			fmt_t f;
			logic [2:0] f3;
			logic [6:0] f7;
			r = '0;
			hit = 1'b1;
			u = UNIT_ADD;
			f = FMT_I;
			f3 = w[14:12];
			f7 = w[31:25];
			case (w[6:0])
				OPC_OP_IMM: begin
					case (f3)
						F3_ADD:  u = UNIT_ADD;
						F3_SLTU: u = UNIT_SLTU;
						F3_SLT:  u = UNIT_SLT;
						F3_AND:  u = UNIT_AND;
						F3_OR:   u = UNIT_OR;
						F3_XOR:  u = UNIT_XOR;
						F3_SLL: begin
							u = UNIT_SLL;
							hit = (f7 == F7_BASE);
						end
						default: begin
							u = (f7 == F7_ALT) ? UNIT_SRA : UNIT_SRL;
							hit = (f7 == F7_BASE) || (f7 == F7_ALT);
						end
					endcase
				end
				OPC_LUI: begin
					u = UNIT_LUI;
					f = FMT_U;
				end
				OPC_AUIPC: begin
					u = UNIT_AUIPC;
					f = FMT_U;
				end
				OPC_OP: begin
					f = FMT_R;
					if (f7 == F7_BASE) begin
						case (f3)
							F3_ADD:  u = UNIT_ADD;
							F3_SLT:  u = UNIT_SLT;
							F3_SLTU: u = UNIT_SLTU;
							F3_SLL:  u = UNIT_SLL;
							F3_AND:  u = UNIT_AND;
							F3_OR:   u = UNIT_OR;
							F3_XOR:  u = UNIT_XOR;
							default: u = UNIT_SRL;
						endcase
					end else if (f7 == F7_ALT && f3 == F3_ADD) begin
						u = UNIT_SUB;
					end else if (f7 == F7_ALT && f3 == F3_SR) begin
						u = UNIT_SRA;
					end else begin
						hit = 1'b0;
					end
				end
				OPC_LOAD: begin
					case (f3)
						F3_BYTE:   u = UNIT_LB;
						F3_HALF:   u = UNIT_LH;
						F3_WORD:   u = UNIT_LW;
						F3_BYTE_U: u = UNIT_LBU;
						F3_HALF_U: u = UNIT_LHU;
						default:   hit = 1'b0;
					endcase
				end
				OPC_STORE: begin
					f = FMT_S;
					case (f3)
						F3_BYTE: u = UNIT_SB;
						F3_HALF: u = UNIT_SH;
						F3_WORD: u = UNIT_SW;
						default: hit = 1'b0;
					endcase
				end
				default: hit = 1'b0;
			endcase
			if (hit) begin
				r.supported = 1'b1;
				r.op_unit = u;
				r.is_load_store = (u >= UNIT_LB);
				case (f)
					FMT_I: begin
						r.dest_field = w[11:7];
						r.first_is_reg = 1'b1;
						r.first_value = {16'b0, w[19:15]};
						r.second_value = w[31:20];
					end
					FMT_U: begin
						// Upper immediate kept unshifted; second operand is all ones.
						r.dest_field = w[11:7];
						r.first_value = {1'b0, w[31:12]};
						r.second_is_reg = 1'b1;
						r.second_value = '1;
					end
					FMT_R: begin
						r.dest_field = w[11:7];
						r.first_is_reg = 1'b1;
						r.first_value = {16'b0, w[19:15]};
						r.second_is_reg = 1'b1;
						r.second_value = {7'b0, w[24:20]};
					end
					default: begin
						// Stores carry rs1 as destination and the split offset, sign-extended.
						r.dest_field = w[19:15];
						r.first_value = {{9{w[31]}}, w[31:25], w[11:7]};
						r.second_is_reg = 1'b1;
						r.second_value = {7'b0, w[24:20]};
					end
				endcase
			end
			r.branch_disp = {w[31], w[7], w[30:25], w[11:8], 1'b0};
			return r;
		endfunction

		function void note_word(logic [31:0] w);
			pending_decode_t p;
			p.word = w;
			p.res = decode_word(w);
			pending.push_back(p);
		endfunction

		task compare_field(logic [31:0] w, string name, logic [20:0] got_v, logic [20:0] want_v);
			if (got_v !== want_v)
				report($sformatf("word %h %s got %h want %h", w, name, got_v, want_v));
		endtask

		task check_result(logic [55:0] d, logic [3:0] u);
			pending_decode_t p;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing pending, tdata %h tuser %h", d, u));
				return;
			end
			p = pending.pop_front();
			compare_field(p.word, "supported", 21'(u[0]), 21'(p.res.supported));
			compare_field(p.word, "first_is_reg", 21'(u[1]), 21'(p.res.first_is_reg));
			compare_field(p.word, "second_is_reg", 21'(u[2]), 21'(p.res.second_is_reg));
			compare_field(p.word, "is_load_store", 21'(u[3]), 21'(p.res.is_load_store));
			compare_field(p.word, "op_unit", 21'(d[4:0]), 21'(p.res.op_unit));
			compare_field(p.word, "dest_field", 21'(d[9:5]), 21'(p.res.dest_field));
			compare_field(p.word, "first_value", d[30:10], $unsigned(p.res.first_value));
			compare_field(p.word, "second_value", 21'(d[42:31]),
				21'($unsigned(p.res.second_value)));
			compare_field(p.word, "branch_disp", 21'(d[55:43]),
				21'($unsigned(p.res.branch_disp)));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [55:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	// While set, neither side idles: a stretch at full rate.
	logic        full_rate = 1'b0;
	int          cycle_count = 0;
	int          stall_left = 0;

	decode_scoreboard sb = new();

	rv32i_subset_operand_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #CLK_HALF clk = ~clk;

	// Gap lengths: mostly none or a few cycles, now and then a long one.
	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function logic [31:0] pack_word(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	// Mostly well-formed instructions with random operand fields; the rest is broken
	// encodings (bad funct3 or funct7) and raw noise.
	function logic [31:0] random_word();
		logic [31:0] w;
		int k;
		w = $urandom;
		k = $urandom_range(0, 99);
		if (k < 22) begin
			w[6:0] = OPC_OP_IMM;
			if (w[14:12] == F3_SLL)
				w[31:25] = F7_BASE;
			else if (w[14:12] == F3_SR)
				w[31:25] = ($urandom_range(0, 1) == 1) ? F7_ALT : F7_BASE;
			if ($urandom_range(0, 9) == 0)
				w[31:25] = 7'($urandom_range(0, 127));
		end else if (k < 32) begin
			w[6:0] = ($urandom_range(0, 1) == 1) ? OPC_LUI : OPC_AUIPC;
		end else if (k < 56) begin
			w[6:0] = OPC_OP;
			w[31:25] = ($urandom_range(0, 9) < 7) ? F7_BASE : F7_ALT;
			if ($urandom_range(0, 9) == 0)
				w[31:25] = 7'($urandom_range(0, 127));
		end else if (k < 71) begin
			w[6:0] = OPC_LOAD;
		end else if (k < 86) begin
			w[6:0] = OPC_STORE;
			w[14:12] = 3'($urandom_range(0, 3));
		end
		return w;
	endfunction

	// Offers one word, after an optional gap, and returns at the edge that takes it.
	task send_word(logic [31:0] w);
		int gap;
		gap = full_rate ? 0 : gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_word(w);
	endtask

	task send_random(int count);
		for (int i = 0; i < count; i++)
			send_word(random_word());
	endtask

	// Holds the input off until every pending result has come out.
	task drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls of the same shape as the input gaps, none at full rate.
	initial begin
		forever begin
			@(posedge clk);
			if (full_rate) begin
				m_axis_tready <= 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	// Every result item taken by the sink is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[rv32i_subset_operand_decoder] ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] directed_words [25];
		// Field extremes, every operation unit, shift encodings with a bad funct7,
		// unsupported words and store offsets at both ends.
		directed_words = '{
			32'h0000_0000,
			32'hFFFF_FFFF,
			pack_word(7'h3F, 5'h1F, 5'd31, F3_ADD, 5'd31, OPC_OP_IMM),
			pack_word(7'h40, 5'h00, 5'd0, F3_SLTU, 5'd0, OPC_OP_IMM),
			pack_word(7'h7F, 5'h1F, 5'd3, F3_SLT, 5'd4, OPC_OP_IMM),
			pack_word(7'h15, 5'h0A, 5'd17, F3_AND, 5'd9, OPC_OP_IMM),
			pack_word(7'h2A, 5'h15, 5'd8, F3_OR, 5'd22, OPC_OP_IMM),
			pack_word(7'h7F, 5'h00, 5'd1, F3_XOR, 5'd30, OPC_OP_IMM),
			pack_word(F7_BASE, 5'd31, 5'd5, F3_SLL, 5'd6, OPC_OP_IMM),
			pack_word(F7_BASE, 5'd0, 5'd31, F3_SR, 5'd0, OPC_OP_IMM),
			pack_word(F7_ALT, 5'd31, 5'd12, F3_SR, 5'd13, OPC_OP_IMM),
			pack_word(7'h01, 5'd3, 5'd2, F3_SLL, 5'd1, OPC_OP_IMM),
			{20'hFFFFF, 5'd31, OPC_LUI},
			{20'h00000, 5'd0, OPC_AUIPC},
			pack_word(F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP),
			pack_word(F7_ALT, 5'd7, 5'd9, F3_SR, 5'd11, OPC_OP),
			pack_word(7'h01, 5'd2, 5'd3, F3_ADD, 5'd4, OPC_OP),
			pack_word(7'h40, 5'h00, 5'd2, F3_BYTE, 5'd3, OPC_LOAD),
			pack_word(7'h12, 5'h05, 5'd14, F3_HALF, 5'd27, OPC_LOAD),
			pack_word(7'h6C, 5'h1B, 5'd20, F3_WORD, 5'd19, OPC_LOAD),
			pack_word(7'h01, 5'h10, 5'd6, F3_BYTE_U, 5'd7, OPC_LOAD),
			pack_word(7'h3F, 5'h1F, 5'd31, F3_HALF_U, 5'd31, OPC_LOAD),
			pack_word(7'h40, 5'd31, 5'd31, F3_BYTE, 5'd0, OPC_STORE),
			pack_word(7'h7F, 5'd0, 5'd0, F3_HALF, 5'h1E, OPC_STORE),
			pack_word(7'h3F, 5'd4, 5'd5, F3_WORD, 5'h1F, OPC_STORE)
		};

		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_words[i])
			send_word(directed_words[i]);
		send_random(280);

		// Let the pipeline run empty before carrying on.
		drain_results();

		// A stretch with both sides at full rate, then idling again.
		full_rate = 1'b1;
		send_random(170);
		full_rate = 1'b0;
		send_random(250);

		drain_results();
		repeat (DRAIN_TICKS) @(posedge clk);
		if (sb.errors == 0)
			$display("[rv32i_subset_operand_decoder] OK");
		else
			$display("[rv32i_subset_operand_decoder] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/rvopd_pkg.sv
hw/rtl/rvopd_match.sv
hw/rtl/rvopd_operand.sv
hw/rtl/rv32i_subset_operand_decoder.sv
tb/testbench.sv
